[hdl/vpcc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vpcc_pkg
// Shared types, widths, codes and helper functions of the vector projection
// chain cross block.
// ----------------------------------------------------------------------------

package vpcc_pkg;

  localparam int IO_W          = 32;
  localparam int COMP_WIDTH    = 32;
  localparam int DEF_FRAC_BITS = 16;

  // exact product, sum of three products, magnitude of that sum
  localparam int PROD_W = 2 * COMP_WIDTH;
  localparam int SUM_W  = PROD_W + 2;
  localparam int MAG_W  = SUM_W - 1;
  localparam int DEN_W  = PROD_W;
  localparam int QUOT_W = COMP_WIDTH + 1;

  localparam logic [COMP_WIDTH-1:0] COMP_MAX = {1'b0, {(COMP_WIDTH - 1){1'b1}}};
  localparam logic [COMP_WIDTH-1:0] COMP_MIN = {1'b1, {(COMP_WIDTH - 1){1'b0}}};

  typedef logic signed [COMP_WIDTH-1:0] comp_t;
  typedef logic [1:0] idx_t;

  typedef struct packed {
    logic signed [IO_W-1:0] in_x;
    logic signed [IO_W-1:0] in_y;
    logic signed [IO_W-1:0] in_z;
    logic                   last;
  } in_item_t;

  typedef struct packed {
    logic signed [IO_W-1:0] res_x;
    logic signed [IO_W-1:0] res_y;
    logic signed [IO_W-1:0] res_z;
    logic [1:0]             status;
  } out_item_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_ZERO_BASE = 2'd1,
    STS_SAT       = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MA_ACC,
    MA_VEC,
    MA_QUOT
  } mul_src_e;

  typedef enum logic [1:0] {
    SUM_HOLD,
    SUM_LOAD,
    SUM_ADD,
    SUM_SUB
  } sum_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED,
    ST_DOT,
    ST_NORM,
    ST_CHECK,
    ST_DIV,
    ST_QSAT,
    ST_PROJ,
    ST_CROSS,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic     take;
    logic     seed;
    logic     mul_en;
    mul_src_e mul_src;
    idx_t     mul_a_idx;
    idx_t     mul_b_idx;
    sum_op_e  sum_op;
    logic     save_dot;
    logic     div_start;
    logic     quot_sat;
    logic     acc_write;
    logic     acc_clear;
    idx_t     wr_idx;
    logic     res_write;
    logic     res_clear;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic den_zero;
    logic div_busy;
  } dp_sts_t;

  typedef struct packed {
    logic [COMP_WIDTH-1:0] val;
    logic                  flag;
  } sat_t;

  // clamp a wide signed value to a component
  function automatic sat_t sat_sum(input logic signed [SUM_W-1:0] x);
    sat_t                     r;
    logic [SUM_W-COMP_WIDTH:0] hi;
    hi     = x[SUM_W-1:COMP_WIDTH-1];
    r.flag = !((&hi) || !(|hi));
    if (r.flag) begin
      r.val = x[SUM_W-1] ? COMP_MIN : COMP_MAX;
    end else begin
      r.val = x[COMP_WIDTH-1:0];
    end
    return r;
  endfunction

  // cyclic successor over the three axes
  function automatic idx_t next_idx(input idx_t i);
    return (i == 2'd2) ? 2'd0 : i + 2'd1;
  endfunction

endpackage

`default_nettype wire

[hdl/vpcc_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vpcc_div
// Restoring radix-2 divider: (mag << FRAC_BITS) / den, one quotient bit per
// cycle, with an up-front overflow check on the quotient width.
// ----------------------------------------------------------------------------

module vpcc_div #(
  parameter int FRAC_BITS = vpcc_pkg::DEF_FRAC_BITS
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [vpcc_pkg::MAG_W-1:0]  mag_i,
  input  wire logic [vpcc_pkg::DEN_W-1:0]  den_i,
  output logic                             busy_o,
  output logic [vpcc_pkg::QUOT_W-1:0]      quot_o,
  output logic                             ovf_o
);

  localparam int NUM_W = vpcc_pkg::MAG_W + FRAC_BITS;
  localparam int DEN_W = vpcc_pkg::DEN_W;
  localparam int QW    = vpcc_pkg::QUOT_W;
  localparam int CNT_W = $clog2(QW + 1);

  logic [NUM_W-1:0]       num;
  logic [DEN_W-1:0]       hi_ext;
  logic [DEN_W-1:0]       rem_q, rem_d;
  logic [DEN_W-1:0]       den_q;
  logic [QW-1:0]          lo_q, lo_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   ovf_q;
  logic [DEN_W:0]         trial;
  logic [DEN_W:0]         diff;
  logic                   ge;

  assign num    = NUM_W'(mag_i) << FRAC_BITS;
  assign hi_ext = DEN_W'(num[NUM_W-1:QW]);

  // shift in the next dividend bit and try the subtraction
  assign trial = {rem_q, lo_q[QW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_comb begin
    rem_d = rem_q;
    lo_d  = lo_q;
    cnt_d = cnt_q;
    if (start_i) begin
      rem_d = hi_ext;
      lo_d  = num[QW-1:0];
      cnt_d = CNT_W'(QW);
    end else if (cnt_q != '0) begin
      rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      lo_d  = {lo_q[QW-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lo_q  <= lo_d;
    if (start_i) begin
      den_q <= den_i;
      ovf_q <= (hi_ext >= den_i);
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = lo_q;
  assign ovf_o  = ovf_q;

endmodule

`default_nettype wire

[hdl/vpcc_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vpcc_dp
// Datapath: vector registers, shared multiplier with product register,
// accumulating adder, divider, clamps, sticky status and output register.
// ----------------------------------------------------------------------------

module vpcc_dp #(
  parameter int FRAC_BITS = vpcc_pkg::DEF_FRAC_BITS
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire vpcc_pkg::in_item_t  in_i,
  input  wire vpcc_pkg::dp_cmd_t   cmd_i,
  output vpcc_pkg::dp_sts_t        sts_o,
  output vpcc_pkg::out_item_t      out_o
);

  localparam int PROD_W = vpcc_pkg::PROD_W;
  localparam int SUM_W  = vpcc_pkg::SUM_W;
  localparam int MAG_W  = vpcc_pkg::MAG_W;
  localparam int DEN_W  = vpcc_pkg::DEN_W;
  localparam int QW     = vpcc_pkg::QUOT_W;

  vpcc_pkg::comp_t vec_q [3];
  vpcc_pkg::comp_t acc_q [3];
  vpcc_pkg::comp_t res_q [3];
  vpcc_pkg::comp_t qs_q;
  vpcc_pkg::comp_t ma, vb;

  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [SUM_W-1:0]  prod_ext;
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic signed [SUM_W-1:0]  dot_q;
  logic signed [SUM_W-1:0]  dot_abs;
  logic signed [SUM_W-1:0]  proj_sh, res_sh;
  logic signed [SUM_W-1:0]  quot_ext, quot_sgn;

  logic [QW-1:0]   quot;
  logic            div_ovf;
  logic            div_busy;

  vpcc_pkg::sat_t    sat_p, sat_r, sat_qv;
  vpcc_pkg::status_e sticky_q, sticky_d, ev;
  vpcc_pkg::out_item_t out_q;
  logic              sat_ev;

  // ---- multiplier ----
  assign vb = vec_q[cmd_i.mul_b_idx];

  always_comb begin
    unique case (cmd_i.mul_src)
      vpcc_pkg::MA_ACC:  ma = acc_q[cmd_i.mul_a_idx];
      vpcc_pkg::MA_VEC:  ma = vb;
      vpcc_pkg::MA_QUOT: ma = qs_q;
      default:           ma = '0;
    endcase
  end

  assign prod_d   = ma * vb;
  assign prod_ext = {{(SUM_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};

  // ---- accumulator ----
  always_comb begin
    unique case (cmd_i.sum_op)
      vpcc_pkg::SUM_HOLD: sum_d = sum_q;
      vpcc_pkg::SUM_LOAD: sum_d = prod_ext;
      vpcc_pkg::SUM_ADD:  sum_d = sum_q + prod_ext;
      vpcc_pkg::SUM_SUB:  sum_d = sum_q - prod_ext;
      default:            sum_d = sum_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    sum_q <= sum_d;
    if (cmd_i.save_dot) begin
      dot_q <= sum_q;
    end
  end

  // ---- divider: |a.b| << frac over |b|^2 ----
  assign dot_abs = dot_q[SUM_W-1] ? -dot_q : dot_q;

  vpcc_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .mag_i   (dot_abs[MAG_W-1:0]),
    .den_i   (sum_q[DEN_W-1:0]),
    .busy_o  (div_busy),
    .quot_o  (quot),
    .ovf_o   (div_ovf)
  );

  assign quot_ext = $signed(SUM_W'(quot));
  assign quot_sgn = dot_q[SUM_W-1] ? -quot_ext : quot_ext;

  always_comb begin
    sat_qv = vpcc_pkg::sat_sum(quot_sgn);
    if (div_ovf) begin
      sat_qv.flag = 1'b1;
      sat_qv.val  = dot_q[SUM_W-1] ? vpcc_pkg::COMP_MIN : vpcc_pkg::COMP_MAX;
    end
  end

  // ---- scaling back by the fraction bits ----
  assign proj_sh = prod_ext >>> FRAC_BITS;
  assign res_sh  = sum_q >>> FRAC_BITS;
  assign sat_p   = vpcc_pkg::sat_sum(proj_sh);
  assign sat_r   = vpcc_pkg::sat_sum(res_sh);

  // ---- vector registers ----
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      vec_q[0] <= in_i.in_x;
      vec_q[1] <= in_i.in_y;
      vec_q[2] <= in_i.in_z;
    end
    if (cmd_i.quot_sat) begin
      qs_q <= sat_qv.val;
    end
    if (cmd_i.res_clear) begin
      res_q[0] <= '0;
      res_q[1] <= '0;
      res_q[2] <= '0;
    end else if (cmd_i.res_write) begin
      res_q[cmd_i.wr_idx] <= sat_r.val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q[0] <= '0;
      acc_q[1] <= '0;
      acc_q[2] <= '0;
    end else if (cmd_i.seed) begin
      acc_q[0] <= vec_q[0];
      acc_q[1] <= vec_q[1];
      acc_q[2] <= vec_q[2];
    end else if (cmd_i.acc_clear) begin
      acc_q[0] <= '0;
      acc_q[1] <= '0;
      acc_q[2] <= '0;
    end else if (cmd_i.acc_write) begin
      acc_q[cmd_i.wr_idx] <= sat_p.val;
    end
  end

  // ---- sticky status, saturation dominates ----
  assign sat_ev = (cmd_i.acc_write && sat_p.flag) || (cmd_i.res_write && sat_r.flag) ||
                  (cmd_i.quot_sat && sat_qv.flag);

  always_comb begin
    ev = vpcc_pkg::STS_OK;
    if (sat_ev) begin
      ev = vpcc_pkg::STS_SAT;
    end else if (cmd_i.acc_clear) begin
      ev = vpcc_pkg::STS_ZERO_BASE;
    end
    sticky_d = sticky_q;
    if (cmd_i.seed) begin
      sticky_d = vpcc_pkg::STS_OK;
    end else if (ev > sticky_q) begin
      sticky_d = ev;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sticky_q <= vpcc_pkg::STS_OK;
    end else begin
      sticky_q <= sticky_d;
    end
  end

  // ---- output register ----
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.res_x  <= res_q[0];
      out_q.res_y  <= res_q[1];
      out_q.res_z  <= res_q[2];
      out_q.status <= sticky_q;
    end
  end

  assign out_o          = out_q;
  assign sts_o.den_zero = (sum_q == '0);
  assign sts_o.div_busy = div_busy;

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> !sts_o.den_zero)
    else $error("divider started with a zero base length");

  a_quot_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.quot_sat |-> !div_busy && $past(cmd_i.sum_op) == vpcc_pkg::SUM_HOLD)
    else $error("quotient taken while the divider is running");

endmodule

`default_nettype wire

[hdl/vpcc_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vpcc_ctrl
// Sequencer: steps the shared multiplier, adder and divider through seeding,
// projection and the final cross product, and owns the output valid flag.
// ----------------------------------------------------------------------------

module vpcc_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_last_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire vpcc_pkg::dp_sts_t  sts_i,
  output vpcc_pkg::dp_cmd_t       cmd_o
);

  localparam logic [2:0] MAC_LAST   = 3'd3;
  localparam logic [2:0] CROSS_LAST = 3'd7;

  vpcc_pkg::state_e state_q, state_d;
  logic [2:0]       step_q, step_d;
  logic             in_run_q, in_run_d;
  logic             last_q, last_d;
  logic             out_valid_q, out_valid_d;
  logic             take;
  logic             out_free;
  vpcc_pkg::idx_t   xi, xj, xk;

  assign take     = in_valid_i && (state_q == vpcc_pkg::ST_IDLE);
  assign out_free = !out_valid_q || out_ready_i;

  // axis triple for the cross product term in progress
  assign xi = step_q[2:1];
  assign xj = vpcc_pkg::next_idx(xi);
  assign xk = vpcc_pkg::next_idx(xj);

  // ---- next state ----
  always_comb begin
    state_d  = state_q;
    step_d   = step_q + 3'd1;
    in_run_d = in_run_q;
    last_d   = last_q;
    unique case (state_q)
      vpcc_pkg::ST_IDLE: begin
        step_d = '0;
        if (take) begin
          last_d = in_last_i;
          if (!in_run_q) begin
            state_d = vpcc_pkg::ST_SEED;
          end else if (in_last_i) begin
            state_d = vpcc_pkg::ST_CROSS;
          end else begin
            state_d = vpcc_pkg::ST_DOT;
          end
        end
      end
      vpcc_pkg::ST_SEED: begin
        step_d = '0;
        if (last_q) begin
          state_d = vpcc_pkg::ST_EMIT;
        end else begin
          in_run_d = 1'b1;
          state_d  = vpcc_pkg::ST_IDLE;
        end
      end
      vpcc_pkg::ST_DOT: begin
        if (step_q == MAC_LAST) begin
          step_d  = '0;
          state_d = vpcc_pkg::ST_NORM;
        end
      end
      vpcc_pkg::ST_NORM: begin
        if (step_q == MAC_LAST) begin
          step_d  = '0;
          state_d = vpcc_pkg::ST_CHECK;
        end
      end
      vpcc_pkg::ST_CHECK: begin
        step_d  = '0;
        state_d = sts_i.den_zero ? vpcc_pkg::ST_IDLE : vpcc_pkg::ST_DIV;
      end
      vpcc_pkg::ST_DIV: begin
        step_d = '0;
        if (!sts_i.div_busy) begin
          state_d = vpcc_pkg::ST_QSAT;
        end
      end
      vpcc_pkg::ST_QSAT: begin
        step_d  = '0;
        state_d = vpcc_pkg::ST_PROJ;
      end
      vpcc_pkg::ST_PROJ: begin
        if (step_q == MAC_LAST) begin
          step_d  = '0;
          state_d = vpcc_pkg::ST_IDLE;
        end
      end
      vpcc_pkg::ST_CROSS: begin
        if (step_q == CROSS_LAST) begin
          step_d  = '0;
          state_d = vpcc_pkg::ST_EMIT;
        end
      end
      vpcc_pkg::ST_EMIT: begin
        step_d = '0;
        if (out_free) begin
          in_run_d = 1'b0;
          state_d  = vpcc_pkg::ST_IDLE;
        end
      end
      default: begin
        step_d  = '0;
        state_d = vpcc_pkg::ST_IDLE;
      end
    endcase
  end

  // ---- datapath commands ----
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      vpcc_pkg::ST_IDLE: begin
        cmd_o.take = take;
      end
      vpcc_pkg::ST_SEED: begin
        cmd_o.seed      = 1'b1;
        cmd_o.res_clear = last_q;
      end
      vpcc_pkg::ST_DOT, vpcc_pkg::ST_NORM: begin
        if (step_q != MAC_LAST) begin
          cmd_o.mul_en    = 1'b1;
          cmd_o.mul_src   = (state_q == vpcc_pkg::ST_DOT) ? vpcc_pkg::MA_ACC : vpcc_pkg::MA_VEC;
          cmd_o.mul_a_idx = step_q[1:0];
          cmd_o.mul_b_idx = step_q[1:0];
        end
        cmd_o.save_dot = (state_q == vpcc_pkg::ST_NORM) && (step_q == '0);
        if (step_q == 3'd1) begin
          cmd_o.sum_op = vpcc_pkg::SUM_LOAD;
        end else if (step_q != '0) begin
          cmd_o.sum_op = vpcc_pkg::SUM_ADD;
        end
      end
      vpcc_pkg::ST_CHECK: begin
        cmd_o.acc_clear = sts_i.den_zero;
        cmd_o.div_start = !sts_i.den_zero;
      end
      vpcc_pkg::ST_DIV: begin
        cmd_o.sum_op = vpcc_pkg::SUM_HOLD;
      end
      vpcc_pkg::ST_QSAT: begin
        cmd_o.quot_sat = 1'b1;
      end
      vpcc_pkg::ST_PROJ: begin
        if (step_q != MAC_LAST) begin
          cmd_o.mul_en    = 1'b1;
          cmd_o.mul_src   = vpcc_pkg::MA_QUOT;
          cmd_o.mul_b_idx = step_q[1:0];
        end
        if (step_q != '0) begin
          cmd_o.acc_write = 1'b1;
          cmd_o.wr_idx    = step_q[1:0] - 2'd1;
        end
      end
      vpcc_pkg::ST_CROSS: begin
        // even step a_j*b_k, odd step a_k*b_j, then the adder closes their difference
        if (xi != 2'd3) begin
          cmd_o.mul_en    = 1'b1;
          cmd_o.mul_src   = vpcc_pkg::MA_ACC;
          cmd_o.mul_a_idx = step_q[0] ? xk : xj;
          cmd_o.mul_b_idx = step_q[0] ? xj : xk;
        end
        if (step_q[0] && (step_q != CROSS_LAST)) begin
          cmd_o.sum_op = vpcc_pkg::SUM_LOAD;
        end else if (!step_q[0] && (step_q != '0)) begin
          cmd_o.sum_op = vpcc_pkg::SUM_SUB;
        end
        if (step_q[0] && (step_q != 3'd1)) begin
          cmd_o.res_write = 1'b1;
          cmd_o.wr_idx    = xi - 2'd1;
        end
      end
      vpcc_pkg::ST_EMIT: begin
        cmd_o.out_load = out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vpcc_pkg::ST_IDLE;
      step_q      <= '0;
      in_run_q    <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      in_run_q    <= in_run_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == vpcc_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

  a_div_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_busy |-> state_q == vpcc_pkg::ST_DIV)
    else $error("divider running outside its wait state");

  a_emit_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_q && !in_run_q && state_q == vpcc_pkg::ST_IDLE)
    else $error("result emitted without closing the run");

  a_run_seeds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !in_run_q) |=> state_q == vpcc_pkg::ST_SEED)
    else $error("first vector of a run not used as seed");

endmodule

`default_nettype wire

[hdl/vector_projection_chain_cross_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vector_projection_chain_cross_core
// Projects an accumulator along a run of 3-D Q16.16 vectors and crosses it
// with the last vector of the run.
//
// Input channel in_valid_i/in_ready_o carries one vector per transaction,
// with a last flag. The first vector of a run seeds the accumulator; each
// following vector without last projects the accumulator onto itself; the
// vector with last is crossed with the accumulator and gives one result
// transaction on out_valid_o/out_ready_i, with a sticky status (0 ok,
// 1 zero-length base seen, 2 saturation). A run of one vector gives zero.
// Steps per transaction, from acceptance until ready again:
//   seed vector: seed, then emit the result when it also carries last
//   projection: dot product and base norm on the shared 32x32 multiplier,
//     zero check (a zero-length base stops there), the 33-step radix-2
//     divider, then the projection passes on the multiplier
//   last vector: cross product passes, then the result is emitted
// One vector is worked on at a time. The result sits in an output register,
// so a stalled receiver holds the block only when a further result is ready
// to be written. Reset clears the sequencer, the run flag and the status,
// and the next vector starts a fresh run.
// ----------------------------------------------------------------------------

module vector_projection_chain_cross_core #(
  parameter int FRAC_BITS = vpcc_pkg::DEF_FRAC_BITS
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire vpcc_pkg::in_item_t   in_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  output vpcc_pkg::out_item_t       out_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i
);

  vpcc_pkg::dp_cmd_t cmd;
  vpcc_pkg::dp_sts_t sts;

  vpcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_i.last),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  vpcc_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

[dv/tb_vector_projection_chain_cross_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vector_projection_chain_cross_core
// Self-checking testbench for the vector projection chain cross block. Runs
// of Q16.16 vectors are sent over the input channel, and a projection and
// cross-product predictor works out each expected result and status. A
// checker compares every output transaction with the oldest prediction.
// Directed runs cover the single-vector run, the zero-length base,
// saturation and extreme components. Random runs follow under several
// sender and receiver idling mixes.
// ----------------------------------------------------------------------------

module tb_vector_projection_chain_cross_core;
  import vpcc_pkg::*;

  localparam int CLK_PERIOD    = 12;
  localparam int RESET_CYCLES  = 12;
  localparam int FRAC          = DEF_FRAC_BITS;
  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PHASE_ITEMS   = 240;

  localparam logic signed [127:0] WIDE_MAX = 128'sd2147483647;
  localparam logic signed [127:0] WIDE_MIN = -128'sd2147483648;
  localparam comp_t               ONE      = 32'sh0001_0000;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  in_item_t  in_data   = '0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  out_item_t out_data;
  logic      out_valid;
  logic      out_ready = 1'b1;

  // predictor state
  comp_t       acc_vec [3];
  bit          run_open;
  logic [1:0]  sticky_sts;
  out_item_t   expected_results [$];

  int          error_count    = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int unsigned cycle_count    = 0;

  vector_projection_chain_cross_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (in_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .out_o       (out_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles", $time, cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic sat_t clamp_wide(input logic signed [127:0] x);
    sat_t r;
    r.flag = (x > WIDE_MAX) || (x < WIDE_MIN);
    if (x > WIDE_MAX) begin
      r.val = COMP_MAX;
    end else if (x < WIDE_MIN) begin
      r.val = COMP_MIN;
    end else begin
      r.val = x[COMP_WIDTH-1:0];
    end
    return r;
  endfunction

  task automatic raise_status(input logic [1:0] ev);
    if (ev > sticky_sts) sticky_sts = ev;
  endtask

  // accumulator becomes its orthogonal projection onto base
  task automatic project_onto(input comp_t base [3], inout bit clamped);
    logic signed [127:0] dot, norm, aw, bw, qw;
    sat_t                s;
    int                  i;
    dot  = '0;
    norm = '0;
    for (i = 0; i < 3; i++) begin
      aw   = acc_vec[i];
      bw   = base[i];
      dot  = dot + aw * bw;
      norm = norm + bw * bw;
    end
    if (norm == 0) begin
      for (i = 0; i < 3; i++) acc_vec[i] = '0;
      raise_status(STS_ZERO_BASE);
    end else begin
      s       = clamp_wide((dot <<< FRAC) / norm);
      clamped = clamped | s.flag;
      qw      = $signed(s.val);
      for (i = 0; i < 3; i++) begin
        bw         = base[i];
        s          = clamp_wide((qw * bw) >>> FRAC);
        acc_vec[i] = s.val;
        clamped    = clamped | s.flag;
      end
    end
  endtask

  task automatic model_vector(input in_item_t v);
    comp_t               vin [3];
    comp_t               res [3];
    logic signed [127:0] aj, ak, bj, bk;
    sat_t                s;
    bit                  clamped;
    out_item_t           r;
    int                  i, j, k;
    vin[0]  = v.in_x;
    vin[1]  = v.in_y;
    vin[2]  = v.in_z;
    clamped = 1'b0;
    r       = '0;
    if (!run_open) begin
      sticky_sts = STS_OK;
      for (i = 0; i < 3; i++) acc_vec[i] = vin[i];
      if (v.last) begin
        // run of one vector gives the zero vector
        r.status = sticky_sts;
        expected_results.push_back(r);
      end else begin
        run_open = 1'b1;
      end
    end else if (!v.last) begin
      project_onto(vin, clamped);
      if (clamped) raise_status(STS_SAT);
    end else begin
      for (i = 0; i < 3; i++) begin
        j      = (i + 1) % 3;
        k      = (i + 2) % 3;
        aj     = acc_vec[j];
        ak     = acc_vec[k];
        bj     = vin[j];
        bk     = vin[k];
        s      = clamp_wide((aj * bk - ak * bj) >>> FRAC);
        res[i] = s.val;
        clamped = clamped | s.flag;
      end
      if (clamped) raise_status(STS_SAT);
      r.res_x  = res[0];
      r.res_y  = res[1];
      r.res_z  = res[2];
      r.status = sticky_sts;
      expected_results.push_back(r);
      run_open = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] expv,
                             input logic [31:0] actv);
    if (actv !== expv) begin
      error_count++;
      $display("%0t mismatch %s expected %h actual %h", $time, name, expv, actv);
    end
  endtask

  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t unexpected transaction expected none actual %h", $time, out_data);
      end else begin
        exp_r = expected_results.pop_front();
        check_field("res_x", exp_r.res_x, out_data.res_x);
        check_field("res_y", exp_r.res_y, out_data.res_y);
        check_field("res_z", exp_r.res_z, out_data.res_z);
        check_field("status", 32'(exp_r.status), 32'(out_data.status));
      end
    end
  end

  // entered and left just after a falling edge
  task automatic send_vector(input comp_t x, input comp_t y, input comp_t z,
                             input bit last);
    in_item_t item;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    item.in_x = x;
    item.in_y = y;
    item.in_z = z;
    item.last = last;
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    model_vector(item);
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic comp_t rand_comp();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return COMP_MAX;
      2:       return COMP_MIN;
      3, 4:    return comp_t'($urandom_range(0, 2 ** 18)) - comp_t'(2 ** 17);
      5, 6:    return comp_t'($urandom_range(0, 2 ** 25)) - comp_t'(2 ** 24);
      default: return comp_t'($urandom);
    endcase
  endfunction

  task automatic test_single_vector_runs();
    send_vector(COMP_MAX, COMP_MIN, COMP_MAX, 1'b1);
    send_vector('0, '0, '0, 1'b1);
    wait_for_results();
  endtask

  task automatic test_zero_length_base();
    send_vector(ONE, 2 * ONE, 3 * ONE, 1'b0);
    send_vector('0, '0, '0, 1'b0);
    send_vector(ONE, '0, '0, 1'b1);
    // zero seed projected onto a proper base
    send_vector('0, '0, '0, 1'b0);
    send_vector(ONE, ONE, ONE, 1'b0);
    send_vector(ONE, -ONE, '0, 1'b1);
    wait_for_results();
  endtask

  task automatic test_saturation();
    // quotient clamps: huge accumulator onto a tiny base
    send_vector(COMP_MAX, '0, '0, 1'b0);
    send_vector(32'sd1, '0, '0, 1'b0);
    send_vector('0, ONE, '0, 1'b1);
    // cross product clamps
    send_vector(COMP_MAX, COMP_MAX, COMP_MIN, 1'b0);
    send_vector(COMP_MIN, COMP_MAX, COMP_MAX, 1'b1);
    // saturation stays over a later zero-length base
    send_vector(COMP_MAX, '0, '0, 1'b0);
    send_vector(32'sd1, '0, '0, 1'b0);
    send_vector('0, '0, '0, 1'b0);
    send_vector(ONE, ONE, ONE, 1'b1);
    wait_for_results();
  endtask

  task automatic test_extremes();
    send_vector(COMP_MIN, COMP_MIN, COMP_MIN, 1'b0);
    send_vector(COMP_MIN, COMP_MIN, COMP_MIN, 1'b0);
    send_vector(COMP_MAX, COMP_MIN, 32'sd1, 1'b1);
    // negative dot product, quotient truncates toward zero
    send_vector(-3 * ONE / 2, ONE / 4, 5 * ONE, 1'b0);
    send_vector(2 * ONE, ONE, -3 * ONE, 1'b0);
    send_vector(ONE / 3, 7 * ONE, -ONE, 1'b1);
    wait_for_results();
  endtask

  task automatic test_random_runs(input int n_items, input int idle_pct,
                                  input int stall_pct, input bit pause_midway);
    int    sent, run_len, i;
    bit    paused;
    comp_t x, y, z;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent   = 0;
    paused = 1'b0;
    while (sent < n_items) begin
      case ($urandom_range(0, 9))
        0:       run_len = 1;
        8:       run_len = $urandom_range(6, 10);
        9:       run_len = $urandom_range(11, 20);
        default: run_len = $urandom_range(2, 5);
      endcase
      for (i = 0; i < run_len; i++) begin
        if ($urandom_range(0, 11) == 0) begin
          x = '0;
          y = '0;
          z = '0;
        end else begin
          x = rand_comp();
          y = rand_comp();
          z = rand_comp();
        end
        send_vector(x, y, z, i == run_len - 1);
        // hold the sender mid-run until the output side has drained
        if (pause_midway && !paused && i == 0 && run_len > 1 && sent >= n_items / 2) begin
          wait_for_results();
          paused = 1'b1;
        end
      end
      sent += run_len;
    end
    wait_for_results();
  endtask

  initial begin
    for (int i = 0; i < 3; i++) acc_vec[i] = '0;
    run_open   = 1'b0;
    sticky_sts = STS_OK;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_single_vector_runs();
    test_zero_length_base();
    test_saturation();
    test_extremes();
    test_random_runs(PHASE_ITEMS, 0, 0, 1'b1);
    test_random_runs(PHASE_ITEMS, 50, 0, 1'b0);
    test_random_runs(PHASE_ITEMS, 0, 50, 1'b0);
    test_random_runs(PHASE_ITEMS, 36, 36, 1'b1);

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
